@@ hdl/mtoi_pkg.sv @@
// Shared constants and types of the motor thermal overload integrator.
`default_nettype none

package mtoi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 31;
  localparam int LIMIT_MULT    = 35;   // 6*6 - 1
  localparam int COOL_NUM      = 58;
  localparam int COOL_DEN      = 100;

  typedef enum logic [1:0] {
    TS_NORMAL   = 2'd0,
    TS_HEATING  = 2'd1,
    TS_COOLING  = 2'd2,
    TS_OVERHEAT = 2'd3
  } mtoi_status_e;

  typedef enum logic [1:0] {
    REG_RATED_CURRENT = 2'd0,
    REG_TRIP_TIME     = 2'd1,
    REG_TIME_STEP     = 2'd2
  } mtoi_reg_e;

endpackage

`default_nettype wire

@@ hdl/mtoi_div.sv @@
// Bit-serial restoring divider giving a saturated fixed-point quotient (a << F) / b.
`default_nettype none

module mtoi_div #(
  parameter int FracBits = mtoi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mtoi_pkg::DATA_W-1:0]   dividend_i,
  input  wire logic [mtoi_pkg::DATA_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [mtoi_pkg::DATA_W-1:0]        quotient_o
);

  localparam int DW      = mtoi_pkg::DATA_W;
  localparam int NumBits = DW + FracBits;
  localparam int CntW    = $clog2(NumBits);

  logic [NumBits-1:0] dvd_q;
  logic [DW-1:0]      dvs_q;
  logic [DW-1:0]      rem_q;
  logic [DW-1:0]      quo_q;
  logic               ovf_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DW:0]        trial;
  logic               ge;
  logic [DW:0]        diff;

  assign trial = {rem_q, dvd_q[NumBits-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {dividend_i, FracBits'(0)};
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
      ovf_q <= ovf_q | quo_q[DW-1];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = ovf_q ? {DW{1'b1}} : quo_q;

endmodule

`default_nettype wire

@@ hdl/motor_thermal_overload_integrator_unit.sv @@
// Top level of the motor thermal overload (i2t) integrator.
`default_nettype none

// One current sample per word in, one status word out. A sample above the rated current
// adds ((I/Irated)^2 - 1) * dt to the heat, clamped at 35 * trip_time_at_six (which sets
// overheat); otherwise a positive heat loses (heat/limit + 0.58) * dt, clamped at zero
// (which clears overheat). A sample above the rated current passes through the divider and
// then two products before its result; a sample that cools a positive heat needs one product
// fewer: the bit-serial divider computes one quotient bit per cycle over 31 + FracBits bits,
// and a single shared 31x31 multiplier does the products one after another. A sample that
// leaves a zero heat untouched skips the divider and goes straight from idle to the output
// state. The input is not ready while a sample is in work; the output register lets the next
// sample start while the last result waits. Configuration writes are taken in any cycle and
// must be made while the block is idle.
module motor_thermal_overload_integrator_unit #(
  parameter int FracBits = mtoi_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] current_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [1:0] thermal_status, [2] ready_res,
                                           // [33:3] heat_level, [39:34] zero
);

  localparam int DW = mtoi_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam logic [DW-1:0] SatMax   = {DW{1'b1}};
  localparam logic [DW-1:0] One      = DW'(1) << FracBits;
  localparam logic [DW-1:0] CoolRate =
    DW'((mtoi_pkg::COOL_NUM << FracBits) / mtoi_pkg::COOL_DEN);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } mtoi_state_e;

  mtoi_state_e state_q, state_d;

  logic [DW-1:0] rated_q, limit_q, step_q;
  logic [DW-1:0] acc_q, acc_d;
  logic          flag_q, flag_d;
  logic          out_valid_q, out_valid_d;
  logic [39:0]   out_data_q;
  logic          heating_q;
  logic [DW-1:0] op_q;
  logic [PW-1:0] prod_q;

  logic          accept, heat_in, div_start, div_done, load_out;
  logic [DW-1:0] div_dvd, div_dvs, quot;
  logic [31:0]   lim_prod;
  logic [DW-1:0] lim_new;
  logic [DW:0]   cool_sum;
  logic [DW-1:0] cool_rate;
  logic [PW-1:0] prod_sh;
  logic [DW-1:0] prod_sat, excess, mul_a, mul_b;
  logic [DW:0]   acc_sum;
  logic [DW-1:0] acc_heat;
  mtoi_pkg::mtoi_status_e status;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign heat_in       = !s_axis_tdata[31] && (s_axis_tdata[DW-1:0] > rated_q);
  assign div_start     = accept && (heat_in || (acc_q != '0));
  assign div_dvd       = heat_in ? s_axis_tdata[DW-1:0] : acc_q;
  assign div_dvs       = heat_in ? rated_q : limit_q;

  assign lim_prod = 32'(cfg_data_i[25:0]) * 32'(mtoi_pkg::LIMIT_MULT);
  assign lim_new  = lim_prod[31] ? SatMax : lim_prod[DW-1:0];

  mtoi_div #(
    .FracBits(FracBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign cool_sum  = {1'b0, quot} + {1'b0, CoolRate};
  assign cool_rate = cool_sum[DW] ? SatMax : cool_sum[DW-1:0];

  assign prod_sh  = prod_q >> FracBits;
  assign prod_sat = (|prod_sh[PW-1:DW]) ? SatMax : prod_sh[DW-1:0];
  assign excess   = (prod_sat >= One) ? (prod_sat - One) : '0;

  always_comb begin
    mul_a = op_q;
    mul_b = heating_q ? op_q : step_q;
    if (state_q == ST_MUL2) begin
      mul_a = excess;
      mul_b = step_q;
    end
  end

  assign acc_sum  = {1'b0, acc_q} + {1'b0, prod_sat};
  assign acc_heat = acc_sum[DW] ? SatMax : acc_sum[DW-1:0];

  always_comb begin
    if (acc_q == '0)          status = mtoi_pkg::TS_NORMAL;
    else if (acc_q == limit_q) status = mtoi_pkg::TS_OVERHEAT;
    else if (flag_q)          status = mtoi_pkg::TS_COOLING;
    else                      status = mtoi_pkg::TS_HEATING;
  end

  assign load_out = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = div_start ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_MUL1;
      end
      ST_MUL1: begin
        state_d = heating_q ? ST_MUL2 : ST_UPD;
      end
      ST_MUL2: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (heating_q) begin
          if (acc_heat >= limit_q) begin
            acc_d  = limit_q;
            flag_d = 1'b1;
          end else begin
            acc_d = acc_heat;
          end
        end else if (prod_sat >= acc_q) begin
          acc_d  = '0;
          flag_d = 1'b0;
        end else begin
          acc_d = acc_q - prod_sat;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rated_q     <= DW'(65536);
      limit_q     <= '0;
      step_q      <= DW'(655);
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (mtoi_pkg::mtoi_reg_e'(cfg_index_i))
          mtoi_pkg::REG_RATED_CURRENT: rated_q <= cfg_data_i[DW-1:0];
          mtoi_pkg::REG_TRIP_TIME:     limit_q <= lim_new;
          mtoi_pkg::REG_TIME_STEP:     step_q  <= cfg_data_i[DW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) heating_q <= heat_in;
    if (state_q == ST_DIV && div_done) op_q <= heating_q ? quot : cool_rate;
    if (state_q == ST_MUL1 || state_q == ST_MUL2) prod_q <= PW'(mul_a) * PW'(mul_b);
    if (load_out) out_data_q <= {6'b0, acc_q, !flag_q, status};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ hdl/mtoi_checker.sv @@
// Port-level assertions for the thermal overload integrator, bound to the top level.
`default_nettype none

module mtoi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after an accepted word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_normal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[1:0] == mtoi_pkg::TS_NORMAL) == (m_axis_tdata[33:3] == 31'd0)))
    else $error("normal status disagrees with zero heat");

  a_cooling_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == mtoi_pkg::TS_COOLING) |-> !m_axis_tdata[2])
    else $error("cooling status with ready set");

  a_heating_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == mtoi_pkg::TS_HEATING) |-> m_axis_tdata[2])
    else $error("heating status with ready clear");

endmodule

bind motor_thermal_overload_integrator_unit mtoi_checker u_mtoi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/mtoi_heat_checker.sv @@
// Checker: tracks the i2t heat state and compares every status word with its prediction.
`timescale 1ns / 1ps

module mtoi_heat_checker #(
  parameter int FracBits = mtoi_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        smp_valid_i,
  input  logic        smp_ready_i,
  input  logic [31:0] smp_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [39:0] res_data_i,
  output int          outstanding_o,
  output int          fails_o
);
  import mtoi_pkg::*;

  localparam logic [31:0] QMAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] ONE_Q      = 32'd1 << FracBits;
  localparam logic [31:0] COOL_FLOOR = 32'((64'(COOL_NUM) << FracBits) / COOL_DEN);

  typedef struct packed {
    logic [30:0]  heat;
    logic         ready;
    mtoi_status_e status;
  } status_word_t;

  logic [31:0]  rated_q;
  logic [31:0]  trip_q;
  logic [31:0]  dt_q;
  logic [31:0]  heat_q;
  logic         overheat_q;
  status_word_t expected_words[$];
  status_word_t exp_w;
  int           fails = 0;

  assign fails_o = fails;

  function automatic logic [31:0] clamp_q(logic [63:0] v);
    return (v > 64'(QMAX)) ? QMAX : v[31:0];
  endfunction

  function automatic logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
    if (b == 32'd0) return QMAX;
    return clamp_q((64'(a) << FracBits) / 64'(b));
  endfunction

  function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
    return clamp_q((64'(a) * 64'(b)) >> FracBits);
  endfunction

  // Applies one current sample to the heat state and returns the status word it yields.
  function automatic status_word_t advance_heat(logic [31:0] smp);
    logic [31:0]  lim;
    logic [31:0]  ratio;
    logic [31:0]  sq;
    logic [31:0]  excess;
    logic [31:0]  gain;
    logic [31:0]  acc;
    logic [31:0]  rate;
    logic [31:0]  loss;
    status_word_t w;
    lim = clamp_q(64'(LIMIT_MULT) * 64'(trip_q));
    if (!smp[31] && smp > rated_q) begin
      ratio  = q_div(smp, rated_q);
      sq     = q_mul(ratio, ratio);
      excess = (sq >= ONE_Q) ? sq - ONE_Q : 32'd0;
      gain   = q_mul(excess, dt_q);
      acc    = clamp_q(64'(heat_q) + 64'(gain));
      if (acc >= lim) begin
        acc        = lim;
        overheat_q = 1'b1;
      end
      heat_q = acc;
    end else if (heat_q != 32'd0) begin
      rate = clamp_q(64'(q_div(heat_q, lim)) + 64'(COOL_FLOOR));
      loss = q_mul(rate, dt_q);
      if (loss >= heat_q) begin
        heat_q     = 32'd0;
        overheat_q = 1'b0;
      end else begin
        heat_q = heat_q - loss;
      end
    end
    if (heat_q == 32'd0) w.status = TS_NORMAL;
    else if (heat_q == lim) w.status = TS_OVERHEAT;
    else if (overheat_q) w.status = TS_COOLING;
    else w.status = TS_HEATING;
    w.ready = !overheat_q;
    w.heat  = heat_q[30:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rated_q    = 32'd65536;
      trip_q     = 32'd0;
      dt_q       = 32'd655;
      heat_q     = 32'd0;
      overheat_q = 1'b0;
      expected_words.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (mtoi_reg_e'(cfg_index_i))
          REG_RATED_CURRENT: rated_q = cfg_data_i & 32'h7FFF_FFFF;
          REG_TRIP_TIME:     trip_q  = cfg_data_i & 32'h03FF_FFFF;
          REG_TIME_STEP:     dt_q    = cfg_data_i & 32'h7FFF_FFFF;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_words.size() == 0) begin
          if (fails < 10)
            $display("%0t: status word %h with none expected", $realtime, res_data_i);
          fails++;
        end else begin
          exp_w = expected_words.pop_front();
          if (res_data_i[1:0] !== exp_w.status || res_data_i[2] !== exp_w.ready ||
              res_data_i[33:3] !== exp_w.heat) begin
            if (fails < 10)
              $display("%0t: expected status %0d ready %0b heat %h, got %0d %0b %h",
                       $realtime, exp_w.status, exp_w.ready, exp_w.heat,
                       res_data_i[1:0], res_data_i[2], res_data_i[33:3]);
            fails++;
          end
        end
      end
      if (smp_valid_i && smp_ready_i) expected_words.push_back(advance_heat(smp_data_i));
      outstanding_o <= expected_words.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top: drives current samples and register writes into the i2t integrator.
`timescale 1ns / 1ps

module tb;
  import mtoi_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          QUIET_FROM  = 30_000;
  localparam int          QUIET_TO    = 42_000;
  localparam logic [31:0] QMAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] AMP         = 32'd65536;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          cyc = 0;
  int          outstanding;
  int          fails;
  logic        quiet;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) m_axis_tready <= quiet || ($urandom_range(0, 99) >= 36);

  motor_thermal_overload_integrator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mtoi_heat_checker heat_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .smp_valid_i   (s_axis_tvalid),
    .smp_ready_i   (s_axis_tready),
    .smp_data_i    (s_axis_tdata),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .outstanding_o (outstanding),
    .fails_o       (fails)
  );

  task automatic push_sample(input logic [31:0] smp);
    while (!quiet && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input mtoi_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_thermal_regs(input logic [31:0] rated, input logic [31:0] trip,
                                   input logic [31:0] dt);
    write_reg(REG_RATED_CURRENT, rated);
    write_reg(REG_TRIP_TIME, trip);
    write_reg(REG_TIME_STEP, dt);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding status word.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Bursts of overload, cool-down and noise around the rated current.
  task automatic random_load_profile(input int n, input logic [31:0] base);
    int          left;
    int          burst;
    int          kind;
    logic [63:0] scaled;
    logic [31:0] smp;
    left = n;
    while (left > 0) begin
      kind  = $urandom_range(0, 9);
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && left > 0; k++) begin
        if (kind < 5) begin
          scaled = (64'(base) * 64'($urandom_range(257, 2048))) >> 8;
          smp    = (scaled > 64'(QMAX)) ? QMAX : scaled[31:0];
          if (smp <= base && base < QMAX) smp = base + 32'd1;
        end else if (kind < 8) begin
          if ($urandom_range(0, 1) == 0) smp = $urandom_range(0, base);
          else smp = $urandom | 32'h8000_0000;
        end else begin
          smp = $urandom;
        end
        push_sample(smp);
        left--;
      end
    end
  endtask

  initial begin
    logic [31:0] rated;
    logic [31:0] trip;
    logic [31:0] dt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero heat limit
    push_sample(QMAX);
    push_sample(AMP + 32'd1);
    push_sample(32'd0);
    push_sample(32'h8000_0000);
    drain_results();

    load_thermal_regs(AMP, AMP, 32'd32768);
    push_sample(QMAX);
    push_sample(32'd0);
    push_sample(32'hFFFF_FFFF);
    push_sample(AMP + 32'd1);
    push_sample(AMP);
    random_load_profile(250, AMP);
    drain_results();

    // ratio truncates to exactly one
    load_thermal_regs(32'h4000_0000, 32'd262144, AMP);
    push_sample(32'h4000_0001);
    push_sample(QMAX);
    random_load_profile(200, 32'h4000_0000);
    drain_results();

    // build up heat, then lower the limit beneath it
    load_thermal_regs(AMP, 32'd655360, AMP);
    repeat (5) push_sample(32'd196608);
    drain_results();
    load_thermal_regs(AMP, AMP, AMP);
    push_sample(32'd0);
    push_sample(32'd196608);
    random_load_profile(200, AMP);
    drain_results();

    // limit and gains saturate
    load_thermal_regs(32'd1, 32'h03FF_FFFF, QMAX);
    push_sample(QMAX);
    push_sample(32'd0);
    random_load_profile(150, 32'd1);
    drain_results();

    // zero divisor, zero time step
    load_thermal_regs(32'd0, 32'd61356675, 32'd0);
    push_sample(32'd1);
    push_sample(QMAX);
    random_load_profile(40, 32'd0);
    drain_results();

    load_thermal_regs(QMAX, 32'd0, 32'd655);
    push_sample(QMAX);
    push_sample(32'd0);
    random_load_profile(40, QMAX);
    drain_results();

    repeat (5) begin
      rated = $urandom_range(1 << 12, 1 << 24);
      trip  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 61356675)
                                          : $urandom_range(0, 1 << 22);
      dt    = $urandom_range(0, 1 << 18);
      load_thermal_regs(rated, trip, dt);
      random_load_profile(70, rated);
      drain_results();
    end

    repeat (60) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
